@@ rtl/bcdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdt_pkg
// Shared constants and types of the bucket column distribution table.
// ----------------------------------------------------------------------------
package bcdt_pkg;

    localparam int MAX_COLUMNS_DEF     = 64;
    localparam int MAX_BUCKET_BITS_DEF = 12;

    localparam int BUCKET_ID_W = 64;
    localparam int COLUMN_W    = 6;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 7;
    localparam int COL_COUNT_W = 7;
    localparam int BKT_BITS_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_BITS  = 8'd1;

    localparam logic [COL_COUNT_W-1:0] COLUMN_COUNT_RST = 7'd1;
    localparam logic [BKT_BITS_W-1:0]  BUCKET_BITS_RST  = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MNEXT,
        S_DIV,
        S_QUOTA,
        S_WRD,
        S_WQ,
        S_WWR,
        S_LOOK
    } t_state;

endpackage

@@ rtl/bcdt_cfg.sv @@
// ----------------------------------------------------------------------------
// bcdt_cfg
// Configuration registers, with the column count and bucket bits brought
// into their usable ranges.
// ----------------------------------------------------------------------------
module bcdt_cfg #(
    parameter int MAX_COLUMNS     = bcdt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_BUCKET_BITS = bcdt_pkg::MAX_BUCKET_BITS_DEF,
    localparam int CNW = $clog2(MAX_COLUMNS + 1),
    localparam int BBW = $clog2(MAX_BUCKET_BITS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [bcdt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bcdt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_cfg_ready,
    output logic [CNW-1:0]                    o_eff_cols,
    output logic [BBW-1:0]                    o_eff_bits
);

    logic [bcdt_pkg::COL_COUNT_W-1:0] r_column_count, n_column_count;
    logic [bcdt_pkg::BKT_BITS_W-1:0]  r_bucket_bits,  n_bucket_bits;
    logic [31:0]                      cols_wide;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_column_count = r_column_count;
        n_bucket_bits  = r_bucket_bits;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bcdt_pkg::REG_COLUMN_COUNT: begin
                    n_column_count = i_cfg_data[bcdt_pkg::COL_COUNT_W-1:0];
                end
                bcdt_pkg::REG_BUCKET_BITS: begin
                    n_bucket_bits = i_cfg_data[bcdt_pkg::BKT_BITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= bcdt_pkg::COLUMN_COUNT_RST;
            r_bucket_bits  <= bcdt_pkg::BUCKET_BITS_RST;
        end else begin
            r_column_count <= n_column_count;
            r_bucket_bits  <= n_bucket_bits;
        end
    end

    always_comb begin
        cols_wide = 32'(r_column_count);
        if (cols_wide == 32'd0) begin
            cols_wide = 32'd1;
        end
        if (cols_wide > 32'(MAX_COLUMNS)) begin
            cols_wide = 32'(MAX_COLUMNS);
        end
        o_eff_cols = cols_wide[CNW-1:0];
        if (32'(r_bucket_bits) > 32'(MAX_BUCKET_BITS)) begin
            o_eff_bits = BBW'(MAX_BUCKET_BITS);
        end else begin
            o_eff_bits = BBW'(r_bucket_bits);
        end
    end

endmodule

@@ rtl/bcdt_div.sv @@
// ----------------------------------------------------------------------------
// bcdt_div
// Restoring divider that takes the bucket count by a column count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcdt_div #(
    parameter int MAX_COLUMNS     = bcdt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_BUCKET_BITS = bcdt_pkg::MAX_BUCKET_BITS_DEF,
    localparam int CNW = $clog2(MAX_COLUMNS + 1),
    localparam int BBW = $clog2(MAX_BUCKET_BITS + 1),
    localparam int NB  = MAX_BUCKET_BITS + 1,
    localparam int CTW = $clog2(NB + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [BBW-1:0]  i_bits,
    input  logic [CNW-1:0]  i_divisor,
    output logic            o_done,
    output logic [NB-1:0]   o_quo,
    output logic [CNW-1:0]  o_rem
);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CTW-1:0]  r_cnt, n_cnt;
    logic [NB-1:0]   r_quo, n_quo;
    logic [CNW-1:0]  r_rem, n_rem;
    logic [CNW-1:0]  r_div, n_div;
    logic [CNW:0]    trial;
    logic [CNW:0]    diff;
    logic            qbit;

    always_comb begin
        trial  = {r_rem, r_quo[NB-1]};
        diff   = trial - {1'b0, r_div};
        qbit   = (trial >= {1'b0, r_div});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CTW'(NB);
            n_quo  = NB'(1) << i_bits;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[NB-2:0], qbit};
            n_rem = qbit ? diff[CNW-1:0] : trial[CNW-1:0];
            n_cnt = r_cnt - CTW'(1);
            if (r_cnt == CTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/bucket_column_distribution_table_unit.sv @@
// ----------------------------------------------------------------------------
// bucket_column_distribution_table_unit
// Maps a bucket identifier to a column through a table that is rebuilt
// column by column whenever the configuration differs from the built one.
// ----------------------------------------------------------------------------
// A lookup into a built table gives its result in the cycle after acceptance,
// and one transaction may be accepted in every cycle while the block is not busy.
// A rebuild clears the table, then for each added column runs the bit-serial
// divider, writes the column quotas and walks the table, each entry passing
// through a read state, a quota read state and a write state.
// Reset leaves the table marked unbuilt, so the first transaction rebuilds it.
module bucket_column_distribution_table_unit #(
    parameter int MAX_COLUMNS     = bcdt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_BUCKET_BITS = bcdt_pkg::MAX_BUCKET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bcdt_pkg::BUCKET_ID_W-1:0]  i_bucket_id,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [bcdt_pkg::COLUMN_W-1:0]     o_column,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bcdt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bcdt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW  = MAX_BUCKET_BITS;
    localparam int NB  = MAX_BUCKET_BITS + 1;
    localparam int QW  = NB;
    localparam int CNW = $clog2(MAX_COLUMNS + 1);
    localparam int CIW = $clog2(MAX_COLUMNS);
    localparam int BBW = $clog2(MAX_BUCKET_BITS + 1);

    logic [CNW-1:0]   eff_cols;
    logic [BBW-1:0]   eff_bits;
    logic [NB-1:0]    n_full;
    logic [AW-1:0]    mask;
    logic             need;
    logic             accept;

    logic             div_start;
    logic             div_done;
    logic [NB-1:0]    div_quo;
    logic [CNW-1:0]   div_rem;

    bcdt_pkg::t_state r_state, n_state;
    logic             r_built, n_built;
    logic [CNW-1:0]   r_built_cols, n_built_cols;
    logic [BBW-1:0]   r_built_bits, n_built_bits;
    logic             r_pend, n_pend;
    logic [CNW-1:0]   r_m, n_m;
    logic [AW-1:0]    r_addr, n_addr;
    logic [CIW-1:0]   r_qi, n_qi;
    logic [CIW-1:0]   r_old, n_old;
    logic [NB-1:0]    r_q_cur, n_q_cur;
    logic [NB-1:0]    r_q_nxt, n_q_nxt;
    logic [CNW-1:0]   r_r_cur, n_r_cur;
    logic [CNW-1:0]   r_r_nxt, n_r_nxt;
    logic [AW-1:0]    r_id, n_id;

    logic [CIW-1:0]   r_map [2**AW];
    logic [CIW-1:0]   r_map_rd;
    logic             map_we;
    logic [AW-1:0]    map_wa;
    logic [CIW-1:0]   map_wd;
    logic [AW-1:0]    map_ra;

    logic [QW-1:0]    r_quota [MAX_COLUMNS];
    logic [QW-1:0]    r_quota_rd;
    logic             quota_we;
    logic [CIW-1:0]   quota_wa;
    logic [QW-1:0]    quota_wd;
    logic [CIW-1:0]   quota_ra;
    logic             lt_cur;
    logic             lt_nxt;

    bcdt_cfg #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_BUCKET_BITS (MAX_BUCKET_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_eff_cols  (eff_cols),
        .o_eff_bits  (eff_bits)
    );

    bcdt_div #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_BUCKET_BITS (MAX_BUCKET_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_bits    (eff_bits),
        .i_divisor (r_m + CNW'(1)),
        .o_done    (div_done),
        .o_quo     (div_quo),
        .o_rem     (div_rem)
    );

    assign n_full = NB'(1) << eff_bits;
    assign mask   = AW'(n_full - NB'(1));
    assign need   = !r_built || (eff_cols != r_built_cols) || (eff_bits != r_built_bits);
    assign o_busy = (r_state != bcdt_pkg::S_IDLE);
    assign accept = i_start && !o_busy;
    assign lt_cur = (CNW'(r_qi) < r_r_cur);
    assign lt_nxt = (CNW'(r_qi) < r_r_nxt);

    always_comb begin
        n_state      = r_state;
        n_built      = r_built;
        n_built_cols = r_built_cols;
        n_built_bits = r_built_bits;
        n_pend       = 1'b0;
        n_m          = r_m;
        n_addr       = r_addr;
        n_qi         = r_qi;
        n_old        = r_old;
        n_q_cur      = r_q_cur;
        n_q_nxt      = r_q_nxt;
        n_r_cur      = r_r_cur;
        n_r_nxt      = r_r_nxt;
        n_id         = r_id;
        div_start    = 1'b0;
        map_we       = 1'b0;
        map_wa       = r_addr;
        map_wd       = '0;
        map_ra       = r_addr;
        quota_we     = 1'b0;
        quota_wa     = r_qi;
        quota_wd     = '0;
        quota_ra     = r_map_rd;
        unique case (r_state)
            bcdt_pkg::S_IDLE: begin
                map_ra = i_bucket_id[AW-1:0] & mask;
                if (accept) begin
                    if (need) begin
                        n_id    = i_bucket_id[AW-1:0] & mask;
                        n_addr  = '0;
                        n_state = bcdt_pkg::S_CLEAR;
                    end else begin
                        n_pend = 1'b1;
                    end
                end
            end
            bcdt_pkg::S_CLEAR: begin
                map_we = 1'b1;
                if (r_addr == mask) begin
                    n_m     = CNW'(1);
                    n_q_cur = n_full;
                    n_r_cur = '0;
                    n_state = bcdt_pkg::S_MNEXT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            bcdt_pkg::S_MNEXT: begin
                if (r_m < eff_cols) begin
                    div_start = 1'b1;
                    n_state   = bcdt_pkg::S_DIV;
                end else begin
                    n_built      = 1'b1;
                    n_built_cols = eff_cols;
                    n_built_bits = eff_bits;
                    n_state      = bcdt_pkg::S_LOOK;
                end
            end
            bcdt_pkg::S_DIV: begin
                if (div_done) begin
                    n_q_nxt = div_quo;
                    n_r_nxt = div_rem;
                    n_qi    = '0;
                    n_state = bcdt_pkg::S_QUOTA;
                end
            end
            bcdt_pkg::S_QUOTA: begin
                quota_we = 1'b1;
                quota_wd = QW'(r_q_cur - r_q_nxt) + QW'(lt_cur) - QW'(lt_nxt);
                if (CNW'(r_qi) == (r_m - CNW'(1))) begin
                    n_addr  = '0;
                    n_state = bcdt_pkg::S_WRD;
                end else begin
                    n_qi = r_qi + CIW'(1);
                end
            end
            bcdt_pkg::S_WRD: begin
                n_state = bcdt_pkg::S_WQ;
            end
            bcdt_pkg::S_WQ: begin
                n_old   = r_map_rd;
                n_state = bcdt_pkg::S_WWR;
            end
            bcdt_pkg::S_WWR: begin
                if ((CNW'(r_old) < r_m) && (r_quota_rd != '0)) begin
                    map_we   = 1'b1;
                    map_wd   = r_m[CIW-1:0];
                    quota_we = 1'b1;
                    quota_wa = r_old;
                    quota_wd = r_quota_rd - QW'(1);
                end
                if (r_addr == mask) begin
                    n_q_cur = r_q_nxt;
                    n_r_cur = r_r_nxt;
                    n_m     = r_m + CNW'(1);
                    n_state = bcdt_pkg::S_MNEXT;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = bcdt_pkg::S_WRD;
                end
            end
            bcdt_pkg::S_LOOK: begin
                map_ra  = r_id;
                n_pend  = 1'b1;
                n_state = bcdt_pkg::S_IDLE;
            end
            default: begin
                n_state = bcdt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bcdt_pkg::S_IDLE;
            r_built      <= 1'b0;
            r_built_cols <= '0;
            r_built_bits <= '0;
            r_pend       <= 1'b0;
            r_m          <= '0;
            r_addr       <= '0;
            r_qi         <= '0;
        end else begin
            r_state      <= n_state;
            r_built      <= n_built;
            r_built_cols <= n_built_cols;
            r_built_bits <= n_built_bits;
            r_pend       <= n_pend;
            r_m          <= n_m;
            r_addr       <= n_addr;
            r_qi         <= n_qi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old   <= n_old;
        r_q_cur <= n_q_cur;
        r_q_nxt <= n_q_nxt;
        r_r_cur <= n_r_cur;
        r_r_nxt <= n_r_nxt;
        r_id    <= n_id;
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wa] <= map_wd;
        end
        r_map_rd <= r_map[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (quota_we) begin
            r_quota[quota_wa] <= quota_wd;
        end
        r_quota_rd <= r_quota[quota_ra];
    end

    assign o_valid  = r_pend;
    assign o_column = bcdt_pkg::COLUMN_W'(r_map_rd);

    a_valid_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past((r_state == bcdt_pkg::S_LOOK) || (accept && !need)))
        else $error("result strobe without a lookup behind it");

    a_walk_old_column : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcdt_pkg::S_WWR) |-> (CNW'(r_old) < r_m))
        else $error("table entry holds a column not yet added");

    a_div_done_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == bcdt_pkg::S_DIV))
        else $error("divider finished outside its wait state");

    a_built_after_rebuild : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcdt_pkg::S_LOOK) |=> (r_built && !need && o_valid))
        else $error("rebuild ended without a matching built configuration");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bucket column distribution table. A directed
// table of lookups and register writes is followed by random phases, each of
// which sets the column count and bucket bits and then issues random lookups
// in bursts. Each returned column is checked against a known column or a local
// column map rebuilt column by column in the same way as the block's table.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int REBUILD_BUDGET = 30000;
    localparam int IDLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TABLE_DEPTH = 1 << bcdt_pkg::MAX_BUCKET_BITS_DEF;
    localparam int DIRECTED_ROWS = 33;
    localparam logic [bcdt_pkg::CFG_INDEX_W-1:0] REG_SPARE_LOW  = 8'd2;
    localparam logic [bcdt_pkg::CFG_INDEX_W-1:0] REG_SPARE_HIGH = 8'hFF;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_LOOKUP,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [bcdt_pkg::CFG_INDEX_W-1:0]   index;
        logic [bcdt_pkg::CFG_DATA_W-1:0]    data;
        logic [bcdt_pkg::BUCKET_ID_W-1:0]   bucket_id;
        logic [bcdt_pkg::COLUMN_W-1:0]      column;
    } t_stim_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_start;
    logic [bcdt_pkg::BUCKET_ID_W-1:0]  i_bucket_id;
    logic                              o_busy;
    logic                              o_valid;
    logic [bcdt_pkg::COLUMN_W-1:0]     o_column;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [bcdt_pkg::CFG_INDEX_W-1:0]  i_cfg_index;
    logic [bcdt_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    logic [bcdt_pkg::COLUMN_W-1:0]     column_map [TABLE_DEPTH];
    int                                map_columns;
    int                                map_bits;
    logic [bcdt_pkg::COL_COUNT_W-1:0]  reg_column_count;
    logic [bcdt_pkg::BKT_BITS_W-1:0]   reg_bucket_bits;

    logic [bcdt_pkg::COLUMN_W-1:0]     pending_columns [$];
    logic [bcdt_pkg::COLUMN_W-1:0]     due_column;
    t_stim_row                         directed_rows [DIRECTED_ROWS];
    int                                mismatches;
    int                                idle_cycles;
    int                                burst_left;

    bucket_column_distribution_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_bucket_id (i_bucket_id),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_column    (o_column),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int column_share(int n, int k, int i);
        return n / k + ((i < n % k) ? 1 : 0);
    endfunction

    function automatic void rebuild_column_map(int cols, int bits);
        int n;
        int m;
        int i;
        int prev;
        int quota [bcdt_pkg::MAX_COLUMNS_DEF];
        n = 1 << bits;
        for (i = 0; i < TABLE_DEPTH; i++) column_map[i] = '0;
        for (m = 1; m < cols; m++) begin
            for (i = 0; i < m; i++)
                quota[i] = column_share(n, m, i) - column_share(n, m + 1, i);
            for (i = 0; i < n; i++) begin
                prev = int'(column_map[i]);
                if (prev < m && quota[prev] > 0) begin
                    column_map[i] = bcdt_pkg::COLUMN_W'(m);
                    quota[prev]--;
                end
            end
        end
        map_columns = cols;
        map_bits = bits;
    endfunction

    function automatic logic [bcdt_pkg::COLUMN_W-1:0] lookup_column(
        logic [bcdt_pkg::BUCKET_ID_W-1:0] id);
        int cols;
        int bits;
        cols = (reg_column_count == 0) ? 1 :
               (reg_column_count > bcdt_pkg::MAX_COLUMNS_DEF) ? bcdt_pkg::MAX_COLUMNS_DEF
                                                              : int'(reg_column_count);
        bits = (reg_bucket_bits > bcdt_pkg::MAX_BUCKET_BITS_DEF) ? bcdt_pkg::MAX_BUCKET_BITS_DEF
                                                                 : int'(reg_bucket_bits);
        if (cols != map_columns || bits != map_bits) rebuild_column_map(cols, bits);
        return column_map[int'(id & ((64'd1 << bits) - 64'd1))];
    endfunction

    function automatic void apply_register_write(logic [bcdt_pkg::CFG_INDEX_W-1:0] index,
                                                 logic [bcdt_pkg::CFG_DATA_W-1:0] data);
        case (index)
            bcdt_pkg::REG_COLUMN_COUNT: reg_column_count = data;
            bcdt_pkg::REG_BUCKET_BITS:  reg_bucket_bits = data[bcdt_pkg::BKT_BITS_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic write_register(input logic [bcdt_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [bcdt_pkg::CFG_DATA_W-1:0] data);
        i_start <= 1'b0;
        if (pending_columns.size() != 0) begin
            while (pending_columns.size() != 0) @(posedge i_clk);
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register_write(index, data);
    endtask

    task automatic issue_lookup(input logic [bcdt_pkg::BUCKET_ID_W-1:0] id, input logic known,
                                input logic [bcdt_pkg::COLUMN_W-1:0] known_column);
        int gap;
        logic [bcdt_pkg::COLUMN_W-1:0] column;
        i_cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_bucket_id <= id;
        do @(posedge i_clk); while (o_busy);
        column = lookup_column(id);
        pending_columns.push_back(known ? known_column : column);
        burst_left--;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_columns.size() == 0) begin
                report_mismatch($sformatf("column %0d with no lookup pending", o_column));
            end else begin
                due_column = pending_columns.pop_front();
                if (o_column !== due_column)
                    report_mismatch($sformatf("column %0d, predicted %0d", o_column, due_column));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim_row row;
        int items_sent;
        int phase_items;
        int eff_columns;
        int max_bits;
        logic [bcdt_pkg::COL_COUNT_W-1:0] count_pick;
        logic [bcdt_pkg::BKT_BITS_W-1:0] bits_pick;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_bucket_id = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        reg_column_count = bcdt_pkg::COLUMN_COUNT_RST;
        reg_bucket_bits = bcdt_pkg::BUCKET_BITS_RST;
        map_columns = int'(bcdt_pkg::COLUMN_COUNT_RST);
        map_bits = int'(bcdt_pkg::BUCKET_BITS_RST);
        for (int i = 0; i < TABLE_DEPTH; i++) column_map[i] = '0;

        // Known columns hold wherever one column or one bucket is in use.
        directed_rows = '{
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'd0,                   6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_COLUMN_COUNT, 7'd0,   64'd0,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_BUCKET_BITS,  7'd0,   64'd0,                   6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'h5555_5555_5555_5555, 6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_COLUMN_COUNT, 7'd64,  64'd0,                   6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'd0,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_COLUMN_COUNT, 7'd127, 64'd0,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_BUCKET_BITS,  7'd6,   64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'd63,                  6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'h8000_0000_0000_0020, 6'd0},
            '{ROW_WRITE,  REG_SPARE_HIGH,             7'h7F,  64'd0,                   6'd0},
            '{ROW_WRITE,  REG_SPARE_LOW,              7'd0,   64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'd5,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_BUCKET_BITS,  7'd15,  64'd0,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_COLUMN_COUNT, 7'd2,   64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'h0000_0000_0000_0FFF, 6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'hFFFF_FFFF_FFFF_F000, 6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'd1,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_BUCKET_BITS,  7'd12,  64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'h800,                 6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_COLUMN_COUNT, 7'd3,   64'd0,                   6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'h7FF,                 6'd0},
            '{ROW_LOOKUP, 8'd0,                       7'd0,   64'h555,                 6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_BUCKET_BITS,  7'd1,   64'd0,                   6'd0},
            '{ROW_WRITE,  bcdt_pkg::REG_COLUMN_COUNT, 7'd1,   64'd0,                   6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'd1,                   6'd0},
            '{ROW_KNOWN,  8'd0,                       7'd0,   64'd0,                   6'd0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_WRITE:  write_register(row.index, row.data);
                ROW_LOOKUP: issue_lookup(row.bucket_id, 1'b0, '0);
                ROW_KNOWN:  issue_lookup(row.bucket_id, 1'b1, row.column);
                default: ;
            endcase
        end

        // Each phase keeps its rebuild short by trading bucket bits against columns.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            count_pick = ($urandom_range(0, 3) == 0)
                         ? bcdt_pkg::COL_COUNT_W'($urandom_range(0, 127))
                         : bcdt_pkg::COL_COUNT_W'($urandom_range(0, 12));
            eff_columns = (count_pick == 0) ? 1 :
                          (count_pick > bcdt_pkg::MAX_COLUMNS_DEF) ? bcdt_pkg::MAX_COLUMNS_DEF
                                                                   : int'(count_pick);
            max_bits = bcdt_pkg::MAX_BUCKET_BITS_DEF;
            while (max_bits > 0 && (3 * (eff_columns - 1) + 1) * (1 << max_bits) > REBUILD_BUDGET)
                max_bits--;
            bits_pick = bcdt_pkg::BKT_BITS_W'($urandom_range(0, max_bits));
            if (max_bits == bcdt_pkg::MAX_BUCKET_BITS_DEF && $urandom_range(0, 3) == 0)
                bits_pick = bcdt_pkg::BKT_BITS_W'($urandom_range(13, 15));
            if ($urandom_range(0, 3) == 0)
                write_register(
                    bcdt_pkg::CFG_INDEX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_HIGH)),
                    bcdt_pkg::CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                write_register(bcdt_pkg::REG_COLUMN_COUNT, bcdt_pkg::CFG_DATA_W'(count_pick));
                write_register(bcdt_pkg::REG_BUCKET_BITS, bcdt_pkg::CFG_DATA_W'(bits_pick));
            end else begin
                write_register(bcdt_pkg::REG_BUCKET_BITS, bcdt_pkg::CFG_DATA_W'(bits_pick));
                write_register(bcdt_pkg::REG_COLUMN_COUNT, bcdt_pkg::CFG_DATA_W'(count_pick));
            end
            phase_items = $urandom_range(40, 160);
            repeat (phase_items) issue_lookup({$urandom, $urandom}, 1'b0, '0);
            items_sent += phase_items;
        end

        i_start <= 1'b0;
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
